// ===== rtl/dip_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dip_pkg
// Types and constants shared by the decimal integer parser modules.
// ----------------------------------------------------------------------------
package dip_pkg;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_U64 = 2'd0;
   localparam kind_type KIND_U32 = 2'd1;
   localparam kind_type KIND_S64 = 2'd2;
   localparam kind_type KIND_S32 = 2'd3;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;

   localparam logic [63:0] U32_MAX = 64'h0000_0000_ffff_ffff;
   localparam logic [63:0] S32_POS = 64'h0000_0000_7fff_ffff;
   localparam logic [63:0] S32_NEG = 64'h0000_0000_8000_0000;
   localparam logic [63:0] S64_POS = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] S64_NEG = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [7:0] char_code;
      logic       terminator;
   } req_type;

   typedef struct packed {
      logic [63:0] parsed_value;
      logic        parse_error;
   } rsp_type;

   typedef struct packed {
      logic [63:0] accumulator;
      logic        negative;
      logic        at_first_char;
      logic        error_seen;
   } state_type;

   localparam state_type STATE_CLEAR = '{
      accumulator: 64'd0, negative: 1'b0, at_first_char: 1'b1, error_seen: 1'b0
   };

endpackage : dip_pkg
`default_nettype wire

// ===== rtl/dip_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dip_step
// Per-item update: digit accumulation with wrap check, and the range check,
// negation and result formatting at the end of a string.
// ----------------------------------------------------------------------------
module dip_step (
   input  wire dip_pkg::kind_type  kind,
   input  wire dip_pkg::req_type   item,
   input  wire dip_pkg::state_type st,
   output dip_pkg::state_type      st_next,
   output dip_pkg::rsp_type        result
);
   import dip_pkg::*;

   logic        is_signed;
   logic        char_is_num;
   logic [3:0]  digit;
   logic [67:0] sum;
   logic        err;
   logic        neg;
   logic [63:0] mag;

   assign is_signed   = (kind == KIND_S64) || (kind == KIND_S32);
   assign char_is_num = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
   assign digit       = 4'(item.char_code - CHAR_ZERO);
   // acc * 10 + d, wrap when the top bits are nonzero
   assign sum = {1'b0, st.accumulator, 3'b000} + {3'b000, st.accumulator, 1'b0}
                + {64'd0, digit};

   always_comb begin
      st_next = st;
      if (!item.terminator) begin
         st_next.at_first_char = 1'b0;
         if (!st.error_seen) begin
            if (st.at_first_char && is_signed && item.char_code == CHAR_MINUS) begin
               st_next.negative = 1'b1;
            end else if (st.at_first_char && is_signed && item.char_code == CHAR_PLUS) begin
               st_next.negative = st.negative;
            end else if (char_is_num) begin
               if (sum[67:64] != 4'd0) begin
                  st_next.error_seen = 1'b1;
               end else begin
                  st_next.accumulator = sum[63:0];
               end
            end else begin
               st_next.error_seen = 1'b1;
            end
         end
      end else begin
         st_next = STATE_CLEAR;
      end
   end

   always_comb begin
      neg = st.negative && is_signed;
      err = st.error_seen || (st.at_first_char && is_signed);
      case (kind)
         KIND_U32: begin
            if (st.accumulator > U32_MAX) err = 1'b1;
         end
         KIND_S64: begin
            if (st.accumulator > (neg ? S64_NEG : S64_POS)) err = 1'b1;
         end
         KIND_S32: begin
            if (st.accumulator > (neg ? S32_NEG : S32_POS)) err = 1'b1;
         end
         default: begin
         end
      endcase
      mag = neg ? (64'd0 - st.accumulator) : st.accumulator;
      result.parsed_value = err ? 64'd0 : mag;
      result.parse_error  = err;
   end

endmodule : dip_step
`default_nettype wire

// ===== rtl/decimal_integer_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_integer_parser
// ASCII decimal string to 64-bit integer with sign and range checking.
//
//   channel  direction  handshake        payload
//   req      in         valid / stall    dip_pkg::req_type
//   rsp      out        valid / stall    dip_pkg::rsp_type
//   csr      in         valid / ready    result_kind, 2 bits
//
// One item per cycle, except while a terminator waits on a stalled result.
// The path is one input register, the digit shift-add and range check, and
// the result register.
// Synchronous reset clears the string state and sets result_kind to 0.
// Only terminator items wait on a stalled result; characters flow on.
// ----------------------------------------------------------------------------
module decimal_integer_parser (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire dip_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output dip_pkg::rsp_type      rsp_data,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire [1:0]             csr_data
);
   import dip_pkg::*;

   logic      in_valid_ff;
   req_type   in_item_ff;
   kind_type  kind_ff;
   state_type st_ff;
   state_type st_in;
   rsp_type   result_in;
   logic      rsp_valid_ff;
   rsp_type   rsp_data_ff;
   logic      advance;
   logic      out_blocked;

   dip_step u_step (
      .kind    (kind_ff),
      .item    (in_item_ff),
      .st      (st_ff),
      .st_next (st_in),
      .result  (result_in)
   );

   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign advance     = in_valid_ff && !(in_item_ff.terminator && out_blocked);
   assign req_stall   = in_valid_ff && !advance;
   assign csr_ready   = !in_valid_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         kind_ff      <= KIND_U64;
         st_ff        <= STATE_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (csr_valid && csr_ready) begin
            kind_ff <= csr_data;
         end
         if (advance) begin
            st_ff <= st_in;
         end
         if (advance && in_item_ff.terminator) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_item_ff <= req_data;
      end
      if (advance && in_item_ff.terminator) begin
         rsp_data_ff <= result_in;
      end
   end

`ifndef SYNTH
   a_clear_after_term: assert property (@(posedge clock) disable iff (reset)
      advance && in_item_ff.terminator |=> st_ff.at_first_char && !st_ff.error_seen)
      else $error("string state not cleared after terminator");

   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.parse_error |-> rsp_data_ff.parsed_value == 64'd0)
      else $error("value not zero on parse error");

   a_error_not_first: assert property (@(posedge clock) disable iff (reset)
      st_ff.error_seen |-> !st_ff.at_first_char)
      else $error("error flagged before any character");

   a_hold_blocked_term: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_item_ff.terminator && out_blocked)
      else $error("input held without a blocked result");
`endif

endmodule : decimal_integer_parser
`default_nettype wire
